FILE: rtl/core/wcrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrs_pkg
// Shared types, register indexes and constants of the corner radius and
// speed planner.
// ----------------------------------------------------------------------------
package wcrs_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RADIUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TURN_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCTION_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_THR_SPEED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_SPEED     = 3'd7;

  localparam logic [15:0] ANGLE_PI = 16'd32768;
  localparam int Z_W = 32;          // binary angle, 2^32 is one turn
  localparam int Z_SHIFT = 15;      // half angle code into binary angle
  localparam int RATIO_SHIFT = 16;  // ratio is x/y in Q18.16 at the defaults
  localparam int PROD_SHIFT = 24;   // Q16.16 * Q8.8 * Q16.16 back to Q16.16
  localparam int RED_SHIFT = 23;
  localparam int T_W = 48;          // min_turn_radius * radius_gain
  localparam int T_SPLIT = 24;
  localparam int SAT_BIT = 56;      // product at or above 2^56 exceeds 32 bits

  typedef struct packed {
    logic [15:0] ang;
    logic        ang_valid;
    logic [1:0]  wp_type;
    logic [31:0] req;
    logic        y_nonpos;
    logic        x_nonpos;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_val(input int step);
    logic signed [Z_W-1:0] v;
    case (step)
      0: v = 32'sd536870912;
      1: v = 32'sd316933406;
      2: v = 32'sd167458907;
      3: v = 32'sd85004756;
      4: v = 32'sd42667331;
      5: v = 32'sd21354465;
      6: v = 32'sd10679838;
      7: v = 32'sd5340245;
      8: v = 32'sd2670163;
      9: v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/wcrs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrs_if
// Waypoint input and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wcrs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] transition_angle;
  logic        angle_valid;
  logic [1:0]  wp_type;
  logic signed [31:0] requested_speed;

  modport source (output valid, transition_angle, angle_valid, wp_type, requested_speed,
                  input ready);
  modport sink (input valid, transition_angle, angle_valid, wp_type, requested_speed,
                output ready);
endinterface

interface wcrs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] accept_radius;
  logic [31:0] target_speed;
  logic [31:0] cruise_speed;

  modport source (output valid, accept_radius, target_speed, cruise_speed,
                  input ready);
  modport sink (input valid, accept_radius, target_speed, cruise_speed,
                output ready);
endinterface

FILE: rtl/core/wcrs_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrs_cordic_cell
// One registered CORDIC rotation step with a fixed shift and arctangent.
// ----------------------------------------------------------------------------
module wcrs_cordic_cell
  import wcrs_pkg::*;
#(
  parameter int XW = 19,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [Z_W-1:0] z_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [Z_W-1:0] z_out
);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  // Arithmetic shift rounds towards minus infinity.
  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - atan_val(STEP);
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + atan_val(STEP);
      end
    end
  end

endmodule

FILE: rtl/core/wcrs_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrs_div_cell
// One registered restoring division step, resolving a single quotient bit.
// ----------------------------------------------------------------------------
module wcrs_div_cell #(
  parameter int NW = 34,
  parameter int DW = 18,
  parameter int QBIT = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_in,
  input  logic [DW-1:0] d_in,
  input  logic [NW-1:0] q_in,
  input  logic [DW-1:0] rem_in,
  output logic [NW-1:0] n_out,
  output logic [DW-1:0] d_out,
  output logic [NW-1:0] q_out,
  output logic [DW-1:0] rem_out
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [NW-1:0] q_next;

  assign trial = {rem_in, n_in[QBIT]};
  assign ge = trial >= {1'b0, d_in};
  assign diff = trial - {1'b0, d_in};

  always_comb begin
    q_next = q_in;
    q_next[QBIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out <= n_in;
      d_out <= d_in;
      q_out <= q_next;
      // The remainder stays below the divisor, so the top bit is always clear.
      rem_out <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule

FILE: rtl/core/waypoint_corner_radius_and_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_corner_radius_and_speed
// Acceptance radius from a CORDIC cot(angle/2) and a pipelined divider,
// with corner speed reduction and cruise speed clamping.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------
//  in_ch    | in  | transition_angle, angle_valid, wp_type, requested_speed
//  out_ch   | out | accept_radius, target_speed, cruise_speed
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One beat is taken per cycle while the output is not stalled. The pipeline
// has one cell per CORDIC step, one divider cell per quotient bit, three
// multiply stages and the output register.
// Reset restores the register defaults and empties the pipeline.
// The whole pipeline advances together; it holds while the output beat
// waits; the input is ready when the output register can move, out of reset.
// ----------------------------------------------------------------------------
module waypoint_corner_radius_and_speed
  import wcrs_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wcrs_in_if.sink               in_ch,
  wcrs_out_if.source            out_ch
);

  localparam int XW = FRAC_BITS + 3;
  localparam int NW = XW - 1 + RATIO_SHIFT;
  localparam int DW = XW - 1;
  localparam int RB = NW;
  localparam int H = RB / 2;
  localparam int HI = RB - H;
  localparam int PW = T_W + RB;
  localparam int ST_A = CORDIC_STEPS + RB;
  localparam int DEPTH = ST_A + 3;

  // Configuration registers.
  logic [31:0] default_radius;
  logic [15:0] radius_gain;
  logic [31:0] radius_max;
  logic [31:0] min_turn_radius;
  logic [15:0] reduction_gain;
  logic [31:0] max_thr_speed;
  logic [31:0] speed_limit;
  logic [31:0] floor_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_radius <= 32'd131072;
      radius_gain <= 16'd256;
      radius_max <= 32'd1310720;
      min_turn_radius <= 32'd65536;
      reduction_gain <= 16'd0;
      max_thr_speed <= 32'd65536;
      speed_limit <= 32'd65536;
      floor_speed <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_RADIUS:  default_radius <= cfg_data;
        REG_RADIUS_GAIN:     radius_gain <= cfg_data[15:0];
        REG_RADIUS_MAX:      radius_max <= cfg_data;
        REG_MIN_TURN_RADIUS: min_turn_radius <= cfg_data;
        REG_REDUCTION_GAIN:  reduction_gain <= cfg_data[15:0];
        REG_MAX_THR_SPEED:   max_thr_speed <= cfg_data;
        REG_SPEED_LIMIT:     speed_limit <= cfg_data;
        REG_FLOOR_SPEED:     floor_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // Radius scale depends on configuration only.
  logic [T_W-1:0] t_prod;
  always_ff @(posedge clk) begin
    t_prod <= T_W'(min_turn_radius) * T_W'(radius_gain);
  end

  logic en;
  logic out_valid;
  assign en = !out_valid || out_ch.ready;
  assign in_ch.ready = en && !rst;

  // Side band travelling alongside the arithmetic cells.
  logic [DEPTH-1:0] vld;
  side_t            sb [DEPTH];
  side_t            sb_mid;

  logic [15:0] ang_sat;
  assign ang_sat = (in_ch.transition_angle > ANGLE_PI) ? ANGLE_PI : in_ch.transition_angle;

  // CORDIC chain.
  logic signed [XW-1:0]  x_c [CORDIC_STEPS+1];
  logic signed [XW-1:0]  y_c [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] z_c [CORDIC_STEPS+1];

  assign x_c[0] = XW'(1) <<< FRAC_BITS;
  assign y_c[0] = '0;
  assign z_c[0] = {1'b0, ang_sat, Z_SHIFT'(0)};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    wcrs_cordic_cell #(.XW(XW), .STEP(i)) u_cell (
      .clk(clk), .en(en),
      .x_in(x_c[i]), .y_in(y_c[i]), .z_in(z_c[i]),
      .x_out(x_c[i+1]), .y_out(y_c[i+1]), .z_out(z_c[i+1])
    );
  end

  // Divider chain: (x << 16) / y, one quotient bit per cell from the top.
  logic [NW-1:0] n_c [RB+1];
  logic [DW-1:0] d_c [RB+1];
  logic [NW-1:0] q_c [RB+1];
  logic [DW-1:0] r_c [RB+1];

  assign n_c[0] = {x_c[CORDIC_STEPS][XW-2:0], RATIO_SHIFT'(0)};
  assign d_c[0] = y_c[CORDIC_STEPS][XW-2:0];
  assign q_c[0] = '0;
  assign r_c[0] = '0;

  for (genvar j = 0; j < RB; j++) begin : g_div
    wcrs_div_cell #(.NW(NW), .DW(DW), .QBIT(RB-1-j)) u_cell (
      .clk(clk), .en(en),
      .n_in(n_c[j]), .d_in(d_c[j]), .q_in(q_c[j]), .rem_in(r_c[j]),
      .n_out(n_c[j+1]), .d_out(d_c[j+1]), .q_out(q_c[j+1]), .rem_out(r_c[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_ch.valid};
    end
  end

  // The CORDIC signs are captured as the beat leaves the last rotation cell.
  always_comb begin
    sb_mid = sb[CORDIC_STEPS-1];
    sb_mid.y_nonpos = (y_c[CORDIC_STEPS] <= 0);
    sb_mid.x_nonpos = (x_c[CORDIC_STEPS] <= 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0].ang <= ang_sat;
      sb[0].ang_valid <= in_ch.angle_valid;
      sb[0].wp_type <= in_ch.wp_type;
      sb[0].req <= in_ch.requested_speed;
      sb[0].y_nonpos <= 1'b0;
      sb[0].x_nonpos <= 1'b0;
      for (int k = 1; k < DEPTH; k++) begin
        sb[k] <= (k == CORDIC_STEPS) ? sb_mid : sb[k-1];
      end
    end
  end

  // Radius product t * ratio from four partial products.
  logic [NW-1:0]       ratio;
  logic [T_SPLIT+H-1:0]  pp00, pp10;
  logic [T_SPLIT+HI-1:0] pp01, pp11;
  logic [T_W+H-1:0]    s0;
  logic [T_W+HI-1:0]   s1;
  logic [PW-1:0]       prod;
  logic                prod_sat;
  logic [31:0]         r_geo;

  assign ratio = q_c[RB];
  assign prod = {{HI{1'b0}}, s0} + {s1, H'(0)};

  // Corner speed reduction.
  logic [15:0]             ang_diff;
  logic [31:0]             red_prod;
  logic [32+FRAC_BITS-1:0] red_full;
  logic [FRAC_BITS:0]      red_cap;
  logic [FRAC_BITS:0]      one_minus;
  logic [32+FRAC_BITS:0]   spd_prod;
  logic [31:0]             spd;

  assign ang_diff = ANGLE_PI - sb[ST_A-1].ang;
  assign red_full = {red_prod, FRAC_BITS'(0)} >> RED_SHIFT;
  assign red_cap = (red_full > (32+FRAC_BITS)'(1) << FRAC_BITS) ?
                   (FRAC_BITS+1)'(1) << FRAC_BITS : red_full[FRAC_BITS:0];
  assign one_minus = ((FRAC_BITS+1)'(1) << FRAC_BITS) - red_cap;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= (T_SPLIT+H)'(t_prod[T_SPLIT-1:0]) * (T_SPLIT+H)'(ratio[H-1:0]);
      pp10 <= (T_SPLIT+H)'(t_prod[T_W-1:T_SPLIT]) * (T_SPLIT+H)'(ratio[H-1:0]);
      pp01 <= (T_SPLIT+HI)'(t_prod[T_SPLIT-1:0]) * (T_SPLIT+HI)'(ratio[RB-1:H]);
      pp11 <= (T_SPLIT+HI)'(t_prod[T_W-1:T_SPLIT]) * (T_SPLIT+HI)'(ratio[RB-1:H]);
      red_prod <= 32'(reduction_gain) * 32'(ang_diff);

      s0 <= (T_W+H)'(pp00) + {pp10, T_SPLIT'(0)};
      s1 <= (T_W+HI)'(pp01) + {pp11, T_SPLIT'(0)};
      spd_prod <= (33+FRAC_BITS)'(max_thr_speed) * (33+FRAC_BITS)'(one_minus);

      prod_sat <= |prod[PW-1:SAT_BIT];
      r_geo <= prod[SAT_BIT-1:PROD_SHIFT];
      spd <= spd_prod[FRAC_BITS+31:FRAC_BITS];
    end
  end

  // Output stage.
  side_t       sc;
  logic [31:0] cruise;
  logic [31:0] radius;
  logic [31:0] arrival;
  logic [31:0] spd_lim;

  assign sc = sb[DEPTH-1];

  always_comb begin
    if (sc.req != 32'd0 && !sc.req[31]) begin
      cruise = (sc.req < speed_limit) ? sc.req : speed_limit;
    end else begin
      cruise = speed_limit;
    end

    if (!sc.ang_valid || radius_max < default_radius) begin
      radius = default_radius;
    end else if (sc.ang == 16'd0 || sc.y_nonpos) begin
      radius = radius_max;
    end else if (sc.x_nonpos) begin
      radius = default_radius;
    end else if (prod_sat) begin
      radius = radius_max;
    end else if (r_geo < default_radius) begin
      radius = default_radius;
    end else if (r_geo > radius_max) begin
      radius = radius_max;
    end else begin
      radius = r_geo;
    end

    spd_lim = (spd > cruise) ? cruise : spd;
    if (!sc.ang_valid || sc.wp_type == 2'd1 || sc.wp_type == 2'd2) begin
      arrival = 32'd0;
    end else if (reduction_gain != 16'd0) begin
      arrival = (spd_lim < floor_speed) ? floor_speed : spd_lim;
    end else begin
      arrival = cruise;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.accept_radius <= radius;
      out_ch.target_speed <= arrival;
      out_ch.cruise_speed <= cruise;
    end
  end

  assign out_ch.valid = out_valid;

  // A stalled pipeline keeps every beat where it is.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

  // A result only appears when a beat left the last stage.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[DEPTH-1]))
    else $error("result without a beat in the last stage");

  // The radius lies within its bounds whenever they are consistent.
  a_radius_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && radius_max >= default_radius |->
      out_ch.accept_radius >= default_radius &&
      out_ch.accept_radius <= radius_max)
    else $error("acceptance radius out of bounds");

endmodule
